FILE: hw/rtl/ple_pkg.sv
// Shared types, sizes and codes of the positional list engine.
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int OUT_CNT_W = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_EMPTY   = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 kind;
        logic [IDX_W-1:0]         idx;
        logic [IDX_W-1:0]         last_idx;
        logic signed [DATA_W-1:0] value;
    } chain_ctl_t;

endpackage

FILE: hw/rtl/ple_cell.sv
// One storage cell of the list chain, holding a single element.
module ple_cell
    import ple_pkg::*;
(
    input  logic                     aclk,
    input  chain_ctl_t               ctl,
    input  logic [IDX_W-1:0]         my_index,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    input  logic signed [DATA_W-1:0] head_data,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        unique case (ctl.kind)
            CELL_HOLD: begin
                data_next = data_reg;
            end
            CELL_INSERT: begin
                if (my_index == ctl.idx) begin
                    data_next = ctl.value;
                end else if (my_index > ctl.idx) begin
                    data_next = left_data;
                end
            end
            CELL_REMOVE: begin
                if (my_index >= ctl.idx) begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE: begin
                if (my_index == ctl.last_idx) begin
                    data_next = head_data;
                end else begin
                    data_next = right_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hw/rtl/ple_chain.sv
// Row of list cells with the head tap and the selected-element tap.
module ple_chain
    import ple_pkg::*;
(
    input  logic                     aclk,
    input  chain_ctl_t               ctl,
    input  logic [IDX_W-1:0]         sel_idx,
    output logic signed [DATA_W-1:0] head_data,
    output logic signed [DATA_W-1:0] sel_data
);

    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_in;
        logic signed [DATA_W-1:0] right_in;

        if (i == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_end
            assign right_in = '0;
        end else begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        ple_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .my_index   (IDX_W'(i)),
            .left_data  (left_in),
            .right_data (right_in),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    assign head_data = cell_data[0];
    assign sel_data  = cell_data[sel_idx];

endmodule

FILE: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: command decode, dump sequencer and output register.
//
//   Port group  Direction  Contents
//   s_*         in         operation in tuser, position and value in tdata
//   m_*         out        status in tuser, element and count in tdata, tlast ends the item
//
// An insert or a delete acts on the cell chain and gives one word.
// A dump of n elements gives n words by rotating the chain n times, one per cycle while
// m_tready is high; a dump of an empty list gives one word. The block takes a new item once
// the dump is over and the output register is free or being taken.
// Reset clears the element count; the cell contents need no reset.
// A stall on m_tready holds the output word and, during a dump, the rotation.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position [4:0], value [36:5], zero fill
    input  logic [2:0]  s_tuser,   // operation [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // element [31:0], count [36:32], zero fill
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast
);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         dump_left_reg, dump_left_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic signed [DATA_W-1:0] out_element_reg, out_element_next;
    logic [OUT_CNT_W-1:0]     out_count_reg, out_count_next;
    logic                     out_last_reg, out_last_next;

    chain_ctl_t               ctl;
    logic signed [DATA_W-1:0] head_data;
    logic signed [DATA_W-1:0] sel_data;

    logic                     accept_in;
    logic                     slot_free;
    op_t                      op;
    logic [POS_W-1:0]         pos;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         pos_m1;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CMP_W-1:0]         cnt_after_ext;
    logic [IDX_W-1:0]         del_idx;
    logic                     is_full;
    logic                     is_empty;
    logic                     pos_ok;
    logic                     dump_emit;

    ple_chain u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .sel_idx   (del_idx),
        .head_data (head_data),
        .sel_data  (sel_data)
    );

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept_in = s_tvalid && s_tready;
    assign dump_emit = (state_reg == ST_DUMP) && slot_free;

    assign op       = op_t'(s_tuser);
    assign pos      = s_tdata[POS_W-1:0];
    assign pos_ext  = CMP_W'(pos);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_m1   = pos_ext - CMP_W'(1);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign cnt_after_ext = CMP_W'(count_next);
    assign del_idx  = (op == OP_DEL_FRONT) ? '0
                    : (op == OP_DEL_END)   ? cnt_m1[IDX_W-1:0]
                                           : pos_m1[IDX_W-1:0];

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        dump_left_next   = dump_left_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_element_next = out_element_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;
        ctl.kind         = CELL_HOLD;
        ctl.idx          = '0;
        ctl.last_idx     = cnt_m1[IDX_W-1:0];
        ctl.value        = s_tdata[POS_W +: DATA_W];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    out_valid_next   = 1'b1;
                    out_status_next  = STATUS_OK;
                    out_element_next = '0;
                    out_last_next    = 1'b1;
                    unique case (op)
                        OP_INS_FRONT, OP_INS_END: begin
                            if (is_full) begin
                                out_status_next = STATUS_FULL;
                            end else begin
                                ctl.kind   = CELL_INSERT;
                                ctl.idx    = (op == OP_INS_FRONT) ? '0
                                                                  : count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INS_POS: begin
                            if (!pos_ok) begin
                                out_status_next = STATUS_INVALID;
                            end else if (is_full) begin
                                out_status_next = STATUS_FULL;
                            end else begin
                                ctl.kind   = CELL_INSERT;
                                ctl.idx    = pos_m1[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_END: begin
                            if (is_empty) begin
                                out_status_next = STATUS_EMPTY;
                            end else begin
                                ctl.kind         = CELL_REMOVE;
                                ctl.idx          = del_idx;
                                out_element_next = sel_data;
                                count_next       = cnt_m1;
                            end
                        end
                        OP_DEL_POS: begin
                            if (is_empty) begin
                                out_status_next = STATUS_EMPTY;
                            end else if (!pos_ok) begin
                                out_status_next = STATUS_INVALID;
                            end else begin
                                ctl.kind         = CELL_REMOVE;
                                ctl.idx          = del_idx;
                                out_element_next = sel_data;
                                count_next       = cnt_m1;
                            end
                        end
                        OP_DUMP: begin
                            if (is_empty) begin
                                out_status_next = STATUS_EMPTY;
                            end else begin
                                out_valid_next = 1'b0;
                                dump_left_next = count_reg;
                                state_next     = ST_DUMP;
                            end
                        end
                        default: begin
                            out_status_next = STATUS_OK;
                        end
                    endcase
                    out_count_next = cnt_after_ext[OUT_CNT_W-1:0];
                end
            end
            ST_DUMP: begin
                if (slot_free) begin
                    ctl.kind         = CELL_ROTATE;
                    out_valid_next   = 1'b1;
                    out_status_next  = STATUS_OK;
                    out_element_next = head_data;
                    out_count_next   = cnt_ext[OUT_CNT_W-1:0];
                    out_last_next    = (dump_left_reg == CNT_W'(1));
                    dump_left_next   = dump_left_reg - CNT_W'(1);
                    if (dump_left_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_left_reg <= dump_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg  <= out_status_next;
        out_element_reg <= out_element_next;
        out_count_reg   <= out_count_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_element_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count exceeds capacity");

    a_dump_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> (dump_left_reg != '0))
        else $error("dump running with nothing left to emit");

    a_dump_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (dump_emit && (dump_left_reg == CNT_W'(1))) |=> (state_reg == ST_IDLE) && m_tlast)
        else $error("dump did not finish after its final word");

    a_no_take_in_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> !s_tready)
        else $error("input taken during a dump");

    a_count_stable_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |=> $stable(count_reg))
        else $error("element count changed during a dump");

endmodule
